[src/dtam_pkg.sv]
// Shared widths, constants, types and calendar helpers of the date and minute adder.
package dtam_pkg;

  // Field widths of the input and result items.
  localparam int unsigned YearW   = 16;
  localparam int unsigned MonW    = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned DeltaW  = 36;
  localparam int unsigned CountW  = 36;
  localparam int unsigned StatusW = 2;

  // Accepted range of the result year.
  localparam int MaxYear = 32767;
  localparam int MinYear = -32768;

  // Depth of the queue between the front and the back.
  localparam int unsigned QDepth = 2;

  // Reciprocal multipliers for the constant divisions.
  // Each is ceil(2^s / d) and is exact over the operand range it serves.
  localparam logic [16:0] RecipM400    = 17'd83887;        // s = 25
  localparam logic [31:0] RecipM45     = 32'd3054198967;   // s = 37
  localparam logic [26:0] RecipM146097 = 27'd120414424;    // s = 44
  localparam logic [18:0] RecipM1460   = 19'd367720;       // s = 29
  localparam logic [17:0] RecipM365    = 18'd183860;       // s = 26
  localparam logic [11:0] RecipM60     = 12'd2185;         // s = 17

  // Bias that keeps year arithmetic nonnegative (128 periods of 400 years).
  localparam logic [17:0] YearBias = 18'd51200;
  // Bias for the day count: 512 periods of 146097 days, less the 60 days
  // from 1 January to 1 March of year 0.
  localparam logic [26:0] DayBias  = 27'd74801604;
  localparam logic [10:0] EraBias  = 11'd512;
  localparam logic [8:0]  EraBiasF = 9'd128;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  // One classified item travelling from the front to the back.
  typedef struct packed {
    logic                     bad;
    logic signed [CountW-1:0] inmin;
    logic signed [DeltaW-1:0] delta;
  } job_t;

  // Day offset of a month counted from March (0 = March .. 11 = February).
  function automatic logic [8:0] mp_start(input logic [3:0] mp);
    logic [8:0] r;
    unique case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of a zero-based month; month codes above December give zero.
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] r;
    unique case (mon)
      4'd1:                       r = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:    r = 5'd30;
      4'd0, 4'd2, 4'd4, 4'd6,
      4'd7, 4'd9, 4'd11:          r = 5'd31;
      default:                    r = 5'd0;
    endcase
    return r;
  endfunction

  // Years within a 400-year cycle divided by 100, for values below 400.
  function automatic logic [1:0] div100(input logic [8:0] yoe);
    logic [14:0] prod;
    prod = 15'(yoe) * 15'd41;
    return prod[13:12];
  endfunction

  // Days from the start of a 400-year cycle (March based) to a year in it.
  function automatic logic [17:0] year_days(input logic [8:0] yoe);
    return 18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(div100(yoe));
  endfunction

endpackage

[src/dtam_if.sv]
// Channel interfaces of the date and minute adder.
interface dtam_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [dtam_pkg::YearW-1:0]      year;
  logic        [dtam_pkg::MonW-1:0]       month;
  logic        [dtam_pkg::DayW-1:0]       day;
  logic        [dtam_pkg::HourW-1:0]      hour;
  logic        [dtam_pkg::MinW-1:0]       minute;
  logic signed [dtam_pkg::DeltaW-1:0]     delta_minutes;

  modport source (output valid, year, month, day, hour, minute, delta_minutes, input ready);
  modport sink   (input valid, year, month, day, hour, minute, delta_minutes, output ready);
endinterface

interface dtam_out_if;
  logic                                   valid;
  logic                                   ready;
  logic        [dtam_pkg::StatusW-1:0]    status;
  logic signed [dtam_pkg::CountW-1:0]     input_minutes;
  logic signed [dtam_pkg::YearW-1:0]      new_year;
  logic        [dtam_pkg::MonW-1:0]       new_month;
  logic        [dtam_pkg::DayW-1:0]       new_day;
  logic        [dtam_pkg::HourW-1:0]      new_hour;
  logic        [dtam_pkg::MinW-1:0]       new_minute;

  modport source (output valid, status, input_minutes, new_year, new_month, new_day,
                  new_hour, new_minute, input ready);
  modport sink   (input valid, status, input_minutes, new_year, new_month, new_day,
                  new_hour, new_minute, output ready);
endinterface

[src/dtam_front.sv]
// Front part: accepts a date, checks it and converts it to a minute count.
module dtam_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  dtam_in_if.sink        in_i,
  output logic           push_valid_o,
  output dtam_pkg::job_t push_job_o,
  input  logic           push_ready_i
);

  typedef enum logic [6:0] {
    F_IDLE = 7'b0000001,
    F_DIV  = 7'b0000010,
    F_MOD  = 7'b0000100,
    F_DOE  = 7'b0001000,
    F_DAYS = 7'b0010000,
    F_MIN  = 7'b0100000,
    F_PUSH = 7'b1000000
  } front_state_e;

  front_state_e state_q, state_d;

  logic signed [15:0] year_q;
  logic [3:0]         mon_q;
  logic [4:0]         dom_q;
  logic [4:0]         hour_q;
  logic [5:0]         minute_q;
  logic signed [35:0] delta_q;
  logic [7:0]         qa_q, qb_q;
  logic signed [8:0]  era_q;
  logic [8:0]         yoe_q, ym_q;
  logic               bad_q;
  logic [17:0]        doe_q;
  logic signed [25:0] days_q;
  logic signed [35:0] inmin_q;

  logic [17:0] yb_w, ya_w;
  logic [33:0] prod_a, prod_b;
  logic [16:0] yoe_w, ym_w;
  logic        leap_w;
  logic [3:0]  mp_w;
  logic [17:0] doe_w;
  logic signed [25:0] days_w;
  logic [35:0] inmin_w;

  // Biased year, and the year counted from March for the day count.
  assign yb_w = {{2{year_q[15]}}, year_q} + dtam_pkg::YearBias;
  assign ya_w = yb_w - {17'd0, (mon_q < 4'd2)};

  // Cycle index of both years by 400.
  assign prod_a = 34'(ya_w[16:0]) * 34'(dtam_pkg::RecipM400);
  assign prod_b = 34'(yb_w[16:0]) * 34'(dtam_pkg::RecipM400);

  // Year within its 400-year cycle.
  assign yoe_w = ya_w[16:0] - 17'(qa_q) * 17'd400;
  assign ym_w  = yb_w[16:0] - 17'(qb_q) * 17'd400;

  // Leap year test and day within the cycle.
  assign leap_w = (year_q[1:0] == 2'd0) && (ym_q != 9'd100) && (ym_q != 9'd200)
                  && (ym_q != 9'd300);
  assign mp_w   = (mon_q < 4'd2) ? (mon_q + 4'd10) : (mon_q - 4'd2);
  assign doe_w  = dtam_pkg::year_days(yoe_q) + 18'(dtam_pkg::mp_start(mp_w)) + 18'(dom_q);

  // Days and minutes since 1 January of year 0.
  assign days_w  = 26'(era_q) * 26'sd146097 + 26'(doe_q) + 26'd60;
  assign inmin_w = 36'(days_q) * 36'd1440 + 36'(hour_q) * 36'd60 + 36'(minute_q);

  // Sequencer of the conversion steps.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (in_i.valid) state_d = F_DIV;
      F_DIV:  state_d = F_MOD;
      F_MOD:  state_d = F_DOE;
      F_DOE:  state_d = F_DAYS;
      F_DAYS: state_d = F_MIN;
      F_MIN:  state_d = F_PUSH;
      F_PUSH: if (push_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers of each step.
  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_i.valid) begin
      year_q   <= in_i.year;
      mon_q    <= in_i.month;
      dom_q    <= in_i.day;
      hour_q   <= in_i.hour;
      minute_q <= in_i.minute;
      delta_q  <= in_i.delta_minutes;
    end
    if (state_q == F_DIV) begin
      qa_q <= prod_a[32:25];
      qb_q <= prod_b[32:25];
    end
    if (state_q == F_MOD) begin
      yoe_q <= yoe_w[8:0];
      ym_q  <= ym_w[8:0];
      era_q <= $signed({1'b0, qa_q} - dtam_pkg::EraBiasF);
    end
    if (state_q == F_DOE) begin
      doe_q <= doe_w;
      bad_q <= (mon_q > 4'd11) || (dom_q >= dtam_pkg::month_len(mon_q, leap_w));
    end
    if (state_q == F_DAYS) begin
      days_q <= days_w;
    end
    if (state_q == F_MIN) begin
      inmin_q <= $signed(inmin_w);
    end
  end

  assign in_i.ready          = (state_q == F_IDLE);
  assign push_valid_o        = (state_q == F_PUSH);
  assign push_job_o.bad      = bad_q;
  assign push_job_o.inmin    = inmin_q;
  assign push_job_o.delta    = delta_q;

endmodule

[src/dtam_queue.sv]
// Two-entry queue that decouples the front from the back.
module dtam_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  dtam_pkg::job_t push_job_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output dtam_pkg::job_t pop_job_o,
  input  logic           pop_ready_i
);

  dtam_pkg::job_t entry_q [dtam_pkg::QDepth];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  logic           push_w, pop_w;

  assign push_ready_o = (count_q != 2'(dtam_pkg::QDepth));
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_job_o    = entry_q[rd_ptr_q];
  assign push_w       = push_valid_i && push_ready_o;
  assign pop_w        = pop_valid_o && pop_ready_i;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_w) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_w) wr_ptr_q <= ~wr_ptr_q;
      if (pop_w)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push_w) - 2'(pop_w);
    end
  end

  // The fill count never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(dtam_pkg::QDepth))
    else $error("queue fill count beyond depth");

endmodule

[src/dtam_back.sv]
// Back part: adds the offset and converts the minute count back to a date.
module dtam_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  input  dtam_pkg::job_t pop_job_i,
  output logic           pop_ready_o,
  dtam_out_if.source     out_o
);

  typedef enum logic [10:0] {
    B_IDLE = 11'b00000000001,
    B_SUM  = 11'b00000000010,
    B_Q45  = 11'b00000000100,
    B_DAYS = 11'b00000001000,
    B_ERA  = 11'b00000010000,
    B_DOE  = 11'b00000100000,
    B_YOE1 = 11'b00001000000,
    B_YOE2 = 11'b00010000000,
    B_DOY  = 11'b00100000000,
    B_MD   = 11'b01000000000,
    B_OUT  = 11'b10000000000
  } back_state_e;

  back_state_e state_q, state_d;

  logic               bad_q;
  logic signed [35:0] inmin_q, delta_q;
  logic [31:0]        x_q, u_q;
  logic               neg_q;
  logic [4:0]         lo5_q;
  logic [26:0]        q_q, zu_q;
  logic [10:0]        rem_q;
  logic [9:0]         qe_q;
  logic [4:0]         hr_q;
  logic [5:0]         min_q;
  logic [17:0]        doe_q, v_q;
  logic signed [10:0] era_q;
  logic [8:0]         yoe_q, doy_q;

  dtam_pkg::status_e  status_q;
  logic signed [35:0] out_inmin_q;
  logic signed [15:0] out_year_q;
  logic [3:0]         out_mon_q;
  logic [4:0]         out_day_q, out_hour_q;
  logic [5:0]         out_min_q;

  logic signed [36:0] sum_w;
  logic [31:0]        x_w, u_w, r45_w;
  logic [63:0]        prod45;
  logic [26:0]        days_w, zu_w, doe_w;
  logic [53:0]        prod_e;
  logic [22:0]        prod_h;
  logic [10:0]        min_w;
  logic [36:0]        prod_d;
  logic [2:0]         cent_w;
  logic               last_w;
  logic [17:0]        v_w;
  logic [35:0]        prod_y;
  logic [17:0]        doy_w;
  logic [3:0]         mp_w, mon_w;
  logic [8:0]         dd_w;
  logic signed [19:0] y_w;
  logic               range_ok_w;

  // Sum and its split into a floor division by 32 and then by 45.
  assign sum_w = 37'(inmin_q) + 37'(delta_q);
  assign x_w   = sum_w[36:5];
  assign u_w   = x_w[31] ? (~x_w + 32'd45) : x_w;
  assign prod45 = 64'(u_q) * 64'(dtam_pkg::RecipM45);

  // Signed day count, minute of day and biased day count.
  assign days_w = neg_q ? (27'd0 - q_q) : q_q;
  assign r45_w  = x_q - {{5{days_w[26]}}, days_w} * 32'd45;
  assign zu_w   = days_w + dtam_pkg::DayBias;

  // 400-year cycle index and hour of day.
  assign prod_e = 54'(zu_q) * 54'(dtam_pkg::RecipM146097);
  assign prod_h = 23'(rem_q) * 23'(dtam_pkg::RecipM60);

  // Day within the cycle and minute of hour.
  assign doe_w = zu_q - 27'(qe_q) * 27'd146097;
  assign min_w = rem_q - 11'(hr_q) * 11'd60;

  // Year within the cycle, step one: remove the leap days.
  assign prod_d = 37'(doe_q) * 37'(dtam_pkg::RecipM1460);
  assign last_w = (doe_q >= 18'd146096);
  assign cent_w = 3'(doe_q >= 18'd36524) + 3'(doe_q >= 18'd73048)
                + 3'(doe_q >= 18'd109572) + 3'(last_w);
  assign v_w    = doe_q - 18'(prod_d[35:29]) + 18'(cent_w) - 18'(last_w);

  // Step two: divide by the days of a common year.
  assign prod_y = 36'(v_q) * 36'(dtam_pkg::RecipM365);

  // Day of the March-based year.
  assign doy_w = doe_q - dtam_pkg::year_days(yoe_q);

  // Month search over the month starts, day of month and calendar year.
  always_comb begin
    mp_w = 4'd0;
    for (int k = 1; k < 12; k++) begin
      mp_w = mp_w + 4'(doy_q >= dtam_pkg::mp_start(4'(k)));
    end
  end
  assign dd_w  = doy_q - dtam_pkg::mp_start(mp_w);
  assign mon_w = (mp_w < 4'd10) ? (mp_w + 4'd2) : (mp_w - 4'd10);
  assign y_w   = 20'(era_q) * 20'sd400 + 20'(yoe_q) + 20'(mp_w >= 4'd10);
  assign range_ok_w = (y_w >= dtam_pkg::MinYear) && (y_w <= dtam_pkg::MaxYear);

  // Sequencer of the conversion steps.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: if (pop_valid_i) state_d = B_SUM;
      B_SUM:  state_d = B_Q45;
      B_Q45:  state_d = B_DAYS;
      B_DAYS: state_d = B_ERA;
      B_ERA:  state_d = B_DOE;
      B_DOE:  state_d = B_YOE1;
      B_YOE1: state_d = B_YOE2;
      B_YOE2: state_d = B_DOY;
      B_DOY:  state_d = B_MD;
      B_MD:   state_d = B_OUT;
      B_OUT:  if (out_o.ready) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers of each step.
  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && pop_valid_i) begin
      bad_q   <= pop_job_i.bad;
      inmin_q <= pop_job_i.inmin;
      delta_q <= pop_job_i.delta;
    end
    if (state_q == B_SUM) begin
      x_q   <= x_w;
      u_q   <= u_w;
      neg_q <= x_w[31];
      lo5_q <= sum_w[4:0];
    end
    if (state_q == B_Q45) begin
      q_q <= prod45[63:37];
    end
    if (state_q == B_DAYS) begin
      zu_q  <= zu_w;
      rem_q <= {r45_w[5:0], lo5_q};
    end
    if (state_q == B_ERA) begin
      qe_q <= prod_e[53:44];
      hr_q <= prod_h[21:17];
    end
    if (state_q == B_DOE) begin
      doe_q <= doe_w[17:0];
      min_q <= min_w[5:0];
      era_q <= $signed({1'b0, qe_q} - dtam_pkg::EraBias);
    end
    if (state_q == B_YOE1) begin
      v_q <= v_w;
    end
    if (state_q == B_YOE2) begin
      yoe_q <= prod_y[34:26];
    end
    if (state_q == B_DOY) begin
      doy_q <= doy_w[8:0];
    end
  end

  // Result register; error cases clear the date fields.
  always_ff @(posedge clk_i) begin
    if (state_q == B_MD) begin
      out_year_q  <= 16'sd0;
      out_mon_q   <= 4'd0;
      out_day_q   <= 5'd0;
      out_hour_q  <= 5'd0;
      out_min_q   <= 6'd0;
      out_inmin_q <= inmin_q;
      if (bad_q) begin
        status_q    <= dtam_pkg::ST_BAD_DATE;
        out_inmin_q <= 36'sd0;
      end else if (!range_ok_w) begin
        status_q <= dtam_pkg::ST_RANGE;
      end else begin
        status_q   <= dtam_pkg::ST_OK;
        out_year_q <= y_w[15:0];
        out_mon_q  <= mon_w;
        out_day_q  <= dd_w[4:0];
        out_hour_q <= hr_q;
        out_min_q  <= min_q;
      end
    end
  end

  assign pop_ready_o         = (state_q == B_IDLE);
  assign out_o.valid         = (state_q == B_OUT);
  assign out_o.status        = status_q;
  assign out_o.input_minutes = out_inmin_q;
  assign out_o.new_year      = out_year_q;
  assign out_o.new_month     = out_mon_q;
  assign out_o.new_day       = out_day_q;
  assign out_o.new_hour      = out_hour_q;
  assign out_o.new_minute    = out_min_q;

  // An invalid date reports no minute count and no date.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && status_q == dtam_pkg::ST_BAD_DATE |->
      out_inmin_q == 36'sd0 && out_year_q == 16'sd0 && out_mon_q == 4'd0)
    else $error("invalid date transaction carries data");

  // A good result always holds a real calendar position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && status_q == dtam_pkg::ST_OK |->
      out_mon_q <= 4'd11 && out_day_q <= 5'd30 && out_hour_q <= 5'd23 && out_min_q <= 6'd59)
    else $error("result date out of calendar range");

  // A result is shown only when the previous state was the month and day step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(state_q == B_MD))
    else $error("result shown without conversion");

endmodule

[src/date_time_add_minutes_core.sv]
// Top level of the date and minute adder: front, queue and back.
// Each transaction is checked and converted by the front, held in the queue and converted back by the back.
// Throughput is set by the back sequencer's steps, which stall while out_o.ready is low;
// the front takes a new transaction only when idle and can run ahead of the back through the queue.
// Reset: rst_ni clears the sequencers and the queue; the block is ready at once.
module date_time_add_minutes_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtam_in_if.sink    in_i,
  dtam_out_if.source out_o
);

  logic           push_valid, push_ready, pop_valid, pop_ready;
  dtam_pkg::job_t push_job, pop_job;

  dtam_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_job_o   (push_job),
    .push_ready_i (push_ready)
  );

  dtam_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_job_i   (push_job),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_job_o    (pop_job),
    .pop_ready_i  (pop_ready)
  );

  dtam_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_job_i   (pop_job),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule
